// ===== hw/rtl/wscp_pkg.sv =====
// Package for the whitespace collapse and pad block: widths, character
// constants, output word selectors and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package wscp_pkg;

    localparam int CHAR_W = 8;
    localparam int CNT_W  = 7;
    localparam int ODATA_W = 16;
    localparam int OUSER_W = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd50;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // Output word selectors
    localparam logic [1:0] SEL_SPACE = 2'd0;
    localparam logic [1:0] SEL_CHAR  = 2'd1;
    localparam logic [1:0] SEL_PAD   = 2'd2;
    localparam logic [1:0] SEL_MARK  = 2'd3;

    // What one input word calls for
    typedef struct packed {
        logic emit_space;
        logic emit_char;
        logic is_end;
        logic err;
        logic pad_any;
    } t_plan;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        t_plan plan_now;
        t_plan plan_held;
        logic  out_free;
        logic  pad_final;
    } t_status;

    function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
    endfunction

endpackage

// ===== hw/rtl/wscp_dp.sv =====
// Datapath: capacity register, per-string counters, word plan, pad counter
// and the output register. Depends on wscp_pkg.
`timescale 1ns / 1ps

module wscp_dp #(
    parameter int MAX_CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wscp_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  logic [wscp_pkg::CHAR_W-1:0]       i_char,
    input  logic                              i_has_char,
    input  logic                              i_end,
    input  wscp_pkg::t_cmd                    i_cmd,
    output wscp_pkg::t_status                 o_status,
    output logic                              o_m_tvalid,
    output logic [wscp_pkg::ODATA_W-1:0]      o_m_tdata,
    output logic [wscp_pkg::OUSER_W-1:0]      o_m_tuser,
    output logic                              o_m_tlast,
    input  logic                              i_m_tready
);
    import wscp_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CAP = CNT_W'(MAX_CAPACITY);

    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_raw, n_raw;
    logic [CNT_W-1:0]  r_emitted, n_emitted;
    logic              r_pending, n_pending;
    logic              r_ovf, n_ovf;
    t_plan             r_plan, n_plan;
    logic [CHAR_W-1:0] r_char;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_pads, n_pads;
    logic              r_ovalid;
    logic [CHAR_W-1:0] r_ochar;
    logic              r_opad, r_olast, r_oerr;
    logic [CNT_W-1:0]  r_olen;

    logic [CNT_W-1:0]  cap_eff;
    logic              live, blank, vis, esp;
    logic              out_free;
    logic [CHAR_W-1:0] w_char;
    logic              w_pad, w_last, w_err;
    logic [CNT_W-1:0]  w_len;

    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (r_cap > MAX_CAP) begin
            cap_eff = MAX_CAP;
        end else begin
            cap_eff = r_cap;
        end
    end

    // Next string state for the word at the slave port
    always_comb begin
        n_raw = r_raw;
        if (i_has_char && (r_raw <= MAX_CAP)) begin
            n_raw = r_raw + CNT_W'(1);
        end
        n_ovf = r_ovf | (i_has_char && (n_raw > cap_eff));
        live  = i_has_char && !n_ovf;
        blank = is_blank(i_char);
        vis   = live && !blank;
        esp   = vis && r_pending;
        if (live && blank && (r_emitted != '0)) begin
            n_pending = 1'b1;
        end else if (vis) begin
            n_pending = 1'b0;
        end else begin
            n_pending = r_pending;
        end
        n_emitted = r_emitted + CNT_W'(esp) + CNT_W'(vis);
        n_pads    = (cap_eff > n_emitted) ? (cap_eff - n_emitted) : '0;
        n_plan.emit_space = esp;
        n_plan.emit_char  = vis;
        n_plan.is_end     = i_end;
        n_plan.err        = i_end && n_ovf;
        n_plan.pad_any    = (n_pads != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_raw     <= '0;
            r_emitted <= '0;
            r_pending <= 1'b0;
            r_ovf     <= 1'b0;
            r_plan    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_plan <= n_plan;
                if (i_end) begin
                    r_raw     <= '0;
                    r_emitted <= '0;
                    r_pending <= 1'b0;
                    r_ovf     <= 1'b0;
                end else begin
                    r_raw     <= n_raw;
                    r_emitted <= n_emitted;
                    r_pending <= n_pending;
                    r_ovf     <= n_ovf;
                end
            end
        end
    end

    // Word payload held for the sequencing that follows
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_char;
            r_len  <= n_emitted;
            r_pads <= n_pads;
        end else if (i_cmd.load && (i_cmd.sel == SEL_PAD)) begin
            r_pads <= r_pads - CNT_W'(1);
        end
    end

    always_comb begin
        w_char = CH_NONE;
        w_pad  = 1'b0;
        w_last = 1'b0;
        w_err  = 1'b0;
        case (i_cmd.sel)
            SEL_SPACE: begin
                w_char = CH_SPACE;
            end
            SEL_CHAR: begin
                w_char = r_char;
                w_last = r_plan.is_end && !r_plan.pad_any;
            end
            SEL_PAD: begin
                w_char = CH_DOT;
                w_pad  = 1'b1;
                w_last = (r_pads == CNT_W'(1));
            end
            SEL_MARK: begin
                w_last = 1'b1;
                w_err  = r_plan.err;
            end
            default: begin
                w_char = CH_NONE;
            end
        endcase
        w_len = (w_last && !w_err) ? r_len : '0;
    end

    assign out_free = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ochar <= w_char;
            r_opad  <= w_pad;
            r_olast <= w_last;
            r_oerr  <= w_err;
            r_olen  <= w_len;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_olen, r_ochar};
    assign o_m_tuser  = {r_oerr, r_opad};
    assign o_m_tlast  = r_olast;

    assign o_status.plan_now  = n_plan;
    assign o_status.plan_held = r_plan;
    assign o_status.out_free  = out_free;
    assign o_status.pad_final = (r_pads == CNT_W'(1));

endmodule

// ===== hw/rtl/wscp_ctrl.sv =====
// Controller: takes input words and steps through the space, character,
// padding and end-marker words that each one produces. Depends on wscp_pkg.
`timescale 1ns / 1ps

module wscp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  wscp_pkg::t_status i_status,
    output wscp_pkg::t_cmd    o_cmd
);
    import wscp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPACE = 3'd1;
    localparam logic [2:0] ST_CHAR  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_MARK  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       accept, load;

    function automatic logic [2:0] first_state(input t_plan p);
        logic [2:0] s;
        if (p.emit_space) begin
            s = ST_SPACE;
        end else if (p.emit_char) begin
            s = ST_CHAR;
        end else if (p.is_end) begin
            s = (p.pad_any && !p.err) ? ST_PAD : ST_MARK;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign load       = (r_state != ST_IDLE) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        o_cmd.accept = accept;
        o_cmd.load   = load;
        o_cmd.sel    = SEL_MARK;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = first_state(i_status.plan_now);
                end
            end
            ST_SPACE: begin
                o_cmd.sel = SEL_SPACE;
                if (load) begin
                    n_state = ST_CHAR;
                end
            end
            ST_CHAR: begin
                o_cmd.sel = SEL_CHAR;
                if (load) begin
                    n_state = (i_status.plan_held.is_end && i_status.plan_held.pad_any)
                              ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                o_cmd.sel = SEL_PAD;
                if (load && i_status.pad_final) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MARK: begin
                o_cmd.sel = SEL_MARK;
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/whitespace_collapse_pad_core.sv =====
// Whitespace collapse and pad, top level: controller plus datapath.
// Depends on wscp_pkg, wscp_ctrl and wscp_dp.
//
// Takes a string one byte word at a time (tuser set when the word carries a
// byte, tlast on the final word) and sends out the normalized text: every
// run of space, tab or newline becomes one space, leading whitespace is
// dropped and a trailing space never appears. On the final word the text is
// padded with dots (tuser bit 0) up to the capacity, and the last output word
// carries tlast and the normalized length. If the raw byte count exceeds the
// capacity, output stops for that string and its end gives one word with
// tuser bit 1 (too long) and tlast. Capacity 0 acts as 1, values above
// MAX_CAPACITY act as MAX_CAPACITY; write it only while the block is idle.
// At most one result word leaves the output register per cycle. A word that
// yields no result (a collapsed blank, an empty word) leaves the block ready
// for the next word; a word that yields results holds s_axis_tready low while
// they are loaded into the output register one by one, and any back-pressure
// holds it low longer. The end of a string also waits out its padding burst.
`timescale 1ns / 1ps

module whitespace_collapse_pad_core #(
    parameter int MAX_CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: capacity
    input  logic                          i_cfg_we,
    input  logic [wscp_pkg::CNT_W-1:0]    i_cfg_wdata,
    // input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [wscp_pkg::CHAR_W-1:0]   s_axis_tdata,  // [7:0] char_in
    input  logic                          s_axis_tuser,  // [0] has_char
    input  logic                          s_axis_tlast,  // end_of_string
    // result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wscp_pkg::ODATA_W-1:0]  m_axis_tdata,  // [7:0] out_char, [14:8] text_length
    output logic [wscp_pkg::OUSER_W-1:0]  m_axis_tuser,  // [0] is_pad, [1] too_long
    output logic                          m_axis_tlast   // last_result
);
    import wscp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller: hand out accept and load strobes, pick each output word.
    wscp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: hold the string state, plan each word, drive the output.
    wscp_dp #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (s_axis_tdata),
        .i_has_char  (s_axis_tuser),
        .i_end       (s_axis_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast),
        .i_m_tready  (m_axis_tready)
    );

    // An error word always closes its string.
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("too_long word without tlast");

    // Padding and error never mark the same word.
    a_pad_not_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("pad and too_long both set");

    // Length is reported only on the closing word.
    a_len_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[14:8] == '0))
        else $error("text_length set on a non-final word");

    // An input word is taken only while no output word is being loaded.
    a_accept_excl_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.accept && cmd.load))
        else $error("accept and load in the same cycle");

endmodule
